### rtl/crb_pkg.sv
// Shared types, constants and helpers for the clipped rectangle blitter.
// Depends on nothing; every other file in rtl refers to it by scoped names.
package crb_pkg;

   localparam int MAX_DIM   = 4096;
   localparam int DIM_W     = 13;
   localparam int ADDR_W    = 25;
   localparam int REQ_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   localparam logic [1:0] CMD_FILL  = 2'd0;
   localparam logic [1:0] CMD_IMAGE = 2'd1;
   localparam logic [1:0] CMD_STEP  = 2'd2;
   localparam logic [1:0] CMD_RSVD  = 2'd3;

   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_ROW_PITCH    = 2'd2;
   localparam logic [1:0] CSR_SCROLL       = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] rect_x;
      logic signed [15:0] rect_y;
      logic [12:0]        rect_w;
      logic [12:0]        rect_h;
      logic [31:0]        fill_color;
      logic [12:0]        source_width;
      logic [12:0]        source_height;
      logic [31:0]        source_base;
   } req_type;

   typedef struct packed {
      logic              write_enable;
      logic [ADDR_W-1:0] write_address;
      logic              from_source;
      logic [31:0]       write_color;
      logic [31:0]       source_address;
      logic              last;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_FILL  = 2'd0,
      KIND_IMAGE = 2'd1,
      KIND_STEP  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type kind;
      req_type  req;
   } entry_type;

   typedef struct packed {
      logic             start;
      logic [DIM_W-1:0] dividend;
      logic [DIM_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIM_W-1:0] quotient;
      logic [DIM_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] lim;
      lim = DIM_W'(MAX_DIM);
      return (v > lim) ? lim : v;
   endfunction

endpackage

### rtl/clipped_rect_fill_and_scaled_blit.sv
// Top level of the clipped rectangle fill and scaled blit engine.
// Depends on crb_pkg, crb_front, crb_back and crb_rsp_queue.
//
// Input channel: push, full, req_data. A word is taken when push is high and
// full is low. Fill and image starts load a command; step words each yield
// one result word; command code 3 is dropped.
// Result channel: empty, pop, rsp_data. The oldest result sits on rsp_data
// while empty is low and leaves when pop is high.
// Configuration: csr_we, csr_index, csr_wdata write frame width, frame
// height, row pitch and scroll; write only while idle.
// Timing: a four-word input queue decouples intake from the pixel engine.
// A step passes through the fetch, multiply and emit states, and emit waits
// while the result queue is full; the next word is fetched only after emit.
// A fill start is loaded in the fetch state; an image start runs the 13-step
// serial divider once for each axis before the next word is fetched.
// Reset returns the engine to idle with both queues empty and the
// configuration at 640 by 480, pitch 640, scroll 0.
// When the receiver stalls, the two-entry result queue fills, the engine
// holds its pixel, and full rises once the input queue is full.
module clipped_rect_fill_and_scaled_blit (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  crb_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output crb_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   crb_pkg::entry_type ent;
   crb_pkg::rsp_type   enq_data;
   logic ent_valid, deq, enq, q_full;

   crb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .deq       (deq),
      .ent_valid (ent_valid),
      .ent       (ent)
   );

   crb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ent_valid (ent_valid),
      .ent       (ent),
      .deq       (deq),
      .enq       (enq),
      .enq_data  (enq_data),
      .q_full    (q_full)
   );

   crb_rsp_queue u_rsp (
      .clock    (clock),
      .reset    (reset),
      .enq      (enq),
      .enq_data (enq_data),
      .q_full   (q_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );
endmodule

### rtl/crb_front.sv
// Front end: input queue that classifies each word on entry.
// Depends on crb_pkg.
module crb_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  crb_pkg::req_type   req_data,
   input  logic               deq,
   output logic               ent_valid,
   output crb_pkg::entry_type ent
);
   localparam int PW = $clog2(crb_pkg::REQ_DEPTH);

   crb_pkg::entry_type mem_ff [crb_pkg::REQ_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;
   logic          do_push, do_pop;
   crb_pkg::kind_type kind;

   always_comb begin
      case (req_data.command)
         crb_pkg::CMD_FILL:  kind = crb_pkg::KIND_FILL;
         crb_pkg::CMD_IMAGE: kind = crb_pkg::KIND_IMAGE;
         crb_pkg::CMD_STEP:  kind = crb_pkg::KIND_STEP;
         default:            kind = crb_pkg::KIND_NONE;
      endcase
   end

   assign full      = (cnt_ff == (PW+1)'(crb_pkg::REQ_DEPTH));
   assign ent_valid = (cnt_ff != '0);
   assign ent       = mem_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = deq && ent_valid;
   assign wr_in     = do_push ? wr_ff + PW'(1) : wr_ff;
   assign rd_in     = do_pop ? rd_ff + PW'(1) : rd_ff;
   assign cnt_in    = cnt_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= '{kind: kind, req: req_data};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

### rtl/crb_div.sv
// Restoring divider, one quotient bit per cycle, for source scale steps.
// Depends on crb_pkg.
module crb_div (
   input  logic                 clock,
   input  logic                 reset,
   input  crb_pkg::div_req_type div_req,
   output crb_pkg::div_rsp_type div_rsp
);
   localparam int W  = crb_pkg::DIM_W;
   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  dvd_ff, dvd_in, dvs_ff, dvs_in, quo_ff, quo_in;
   logic [W:0]    rem_ff, rem_in, shifted;
   logic          fits;

   assign shifted = {rem_ff[W-1:0], dvd_ff[W-1]};
   assign fits    = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         quo_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? shifted - {1'b0, dvs_ff} : shifted;
         quo_in = {quo_ff[W-2:0], fits};
         dvd_in = {dvd_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff[W-1:0];
endmodule

### rtl/crb_rsp_queue.sv
// Result queue between the pixel engine and the result port.
// Depends on crb_pkg.
module crb_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             enq,
   input  crb_pkg::rsp_type enq_data,
   output logic             q_full,
   output logic             empty,
   input  logic             pop,
   output crb_pkg::rsp_type rsp_data
);
   localparam int PW = $clog2(crb_pkg::RSP_DEPTH);

   crb_pkg::rsp_type mem_ff [crb_pkg::RSP_DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [PW:0]   cnt_ff, cnt_in;
   logic          do_enq, do_pop;

   assign q_full   = (cnt_ff == (PW+1)'(crb_pkg::RSP_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign rsp_data = mem_ff[rd_ff];
   assign do_enq   = enq && !q_full;
   assign do_pop   = pop && !empty;
   assign cnt_in   = cnt_ff + (PW+1)'(do_enq) - (PW+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (do_enq) begin
         mem_ff[wr_ff] <= enq_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_enq) begin
            wr_ff <= wr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ff <= rd_ff + PW'(1);
         end
         cnt_ff <= cnt_in;
      end
   end
endmodule

### rtl/crb_back.sv
// Back end: command registers, pixel walker, clipping and address math.
// Depends on crb_pkg and crb_div.
module crb_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               ent_valid,
   input  crb_pkg::entry_type ent,
   output logic               deq,
   output logic               enq,
   output crb_pkg::rsp_type   enq_data,
   input  logic               q_full
);
   localparam int W = crb_pkg::DIM_W;

   typedef enum logic [4:0] {
      ST_FETCH = 5'b00001,
      ST_DIVX  = 5'b00010,
      ST_DIVY  = 5'b00100,
      ST_MUL   = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_FILL  = 2'd1,
      MODE_IMAGE = 2'd2
   } mode_type;

   state_type   st_ff, st_in;
   mode_type    mode_ff, mode_in;
   logic [W-1:0]  fw_ff, fh_ff;
   logic [13:0]   pitch_ff;
   logic [15:0]   scroll_ff;
   logic [W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [15:0]   left_ff, left_in;
   logic [16:0]   top_ff, top_in;
   logic [W-1:0]  w_ff, w_in, h_ff, h_in, sw_ff, sw_in, sh_ff, sh_in;
   logic [31:0]   color_ff, color_in, base_ff, base_in;
   logic [W-1:0]  qx_ff, qx_in, rx_ff, rx_in, qy_ff, qy_in, ry_ff, ry_in;
   logic [W-1:0]  sx_ff, sx_in, xr_ff, xr_in, sy_ff, sy_in, yr_ff, yr_in;
   logic [26:0]   wprod_ff;
   logic [25:0]   sprod_ff;
   logic [W-1:0]  pxl_ff;
   logic          in_frame_ff, last_ff;

   crb_pkg::div_req_type div_req;
   crb_pkg::div_rsp_type div_rsp;

   logic [W-1:0]  nw, nh, nsw, nsh;
   logic          start_ok;
   logic signed [16:0] px;
   logic signed [17:0] py;
   logic          in_frame, is_last;
   logic [W:0]    xsum, ysum;
   logic [26:0]   waddr;

   crb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign nw  = crb_pkg::sat_dim(ent.req.rect_w);
   assign nh  = crb_pkg::sat_dim(ent.req.rect_h);
   assign nsw = crb_pkg::sat_dim(ent.req.source_width);
   assign nsh = crb_pkg::sat_dim(ent.req.source_height);
   assign start_ok = (nw != '0) && (nh != '0) &&
      !(ent.kind == crb_pkg::KIND_IMAGE && (nsw == '0 || nsh == '0));

   assign px = $signed({left_ff[15], left_ff}) + $signed({4'b0, col_ff});
   assign py = $signed({top_ff[16], top_ff}) + $signed({5'b0, row_ff});
   assign in_frame = !px[16] && !py[17] && (px[15:0] < {3'b0, fw_ff}) &&
                     (py[16:0] < {4'b0, fh_ff});
   assign is_last = ({1'b0, col_ff} + 14'd1 == {1'b0, w_ff}) &&
                    ({1'b0, row_ff} + 14'd1 == {1'b0, h_ff});
   assign xsum  = {1'b0, xr_ff} + {1'b0, rx_ff};
   assign ysum  = {1'b0, yr_ff} + {1'b0, ry_ff};
   assign waddr = wprod_ff + {14'b0, pxl_ff};

   always_comb begin
      st_in    = st_ff;
      mode_in  = mode_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      left_in  = left_ff;
      top_in   = top_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      sw_in    = sw_ff;
      sh_in    = sh_ff;
      color_in = color_ff;
      base_in  = base_ff;
      qx_in    = qx_ff;
      rx_in    = rx_ff;
      qy_in    = qy_ff;
      ry_in    = ry_ff;
      sx_in    = sx_ff;
      xr_in    = xr_ff;
      sy_in    = sy_ff;
      yr_in    = yr_ff;
      deq      = 1'b0;
      enq      = 1'b0;
      div_req  = '{start: 1'b0, dividend: nsw, divisor: nw};
      unique case (st_ff)
         ST_FETCH: begin
            if (ent_valid) begin
               deq = 1'b1;
               case (ent.kind)
                  crb_pkg::KIND_FILL, crb_pkg::KIND_IMAGE: begin
                     left_in  = ent.req.rect_x;
                     top_in   = 17'($signed({ent.req.rect_y[15], ent.req.rect_y}) -
                                    $signed({scroll_ff[15], scroll_ff}));
                     w_in     = nw;
                     h_in     = nh;
                     sw_in    = nsw;
                     sh_in    = nsh;
                     color_in = ent.req.fill_color;
                     base_in  = ent.req.source_base;
                     col_in   = '0;
                     row_in   = '0;
                     sx_in    = '0;
                     xr_in    = '0;
                     sy_in    = '0;
                     yr_in    = '0;
                     if (!start_ok) begin
                        mode_in = MODE_IDLE;
                     end else if (ent.kind == crb_pkg::KIND_FILL) begin
                        mode_in = MODE_FILL;
                     end else begin
                        mode_in = MODE_IMAGE;
                        div_req.start = 1'b1;
                        st_in = ST_DIVX;
                     end
                  end
                  crb_pkg::KIND_STEP: st_in = ST_MUL;
                  default: ;
               endcase
            end
         end
         ST_DIVX: begin
            div_req.dividend = sh_ff;
            div_req.divisor  = h_ff;
            if (div_rsp.done) begin
               qx_in = div_rsp.quotient;
               rx_in = div_rsp.remainder;
               div_req.start = 1'b1;
               st_in = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_rsp.done) begin
               qy_in = div_rsp.quotient;
               ry_in = div_rsp.remainder;
               st_in = ST_FETCH;
            end
         end
         ST_MUL: st_in = ST_EMIT;
         ST_EMIT: begin
            if (!q_full) begin
               enq   = 1'b1;
               st_in = ST_FETCH;
               if (mode_ff != MODE_IDLE) begin
                  if (last_ff) begin
                     mode_in = MODE_IDLE;
                     col_in  = '0;
                     row_in  = '0;
                  end else if ({1'b0, col_ff} + 14'd1 >= {1'b0, w_ff}) begin
                     col_in = '0;
                     row_in = row_ff + W'(1);
                     sx_in  = '0;
                     xr_in  = '0;
                     if (ysum >= {1'b0, h_ff}) begin
                        yr_in = W'(ysum - {1'b0, h_ff});
                        sy_in = sy_ff + qy_ff + W'(1);
                     end else begin
                        yr_in = ysum[W-1:0];
                        sy_in = sy_ff + qy_ff;
                     end
                  end else begin
                     col_in = col_ff + W'(1);
                     if (xsum >= {1'b0, w_ff}) begin
                        xr_in = W'(xsum - {1'b0, w_ff});
                        sx_in = sx_ff + qx_ff + W'(1);
                     end else begin
                        xr_in = xsum[W-1:0];
                        sx_in = sx_ff + qx_ff;
                     end
                  end
               end
            end
         end
         default: st_in = ST_FETCH;
      endcase
   end

   always_comb begin
      enq_data = '0;
      if (mode_ff == MODE_IDLE) begin
         enq_data.last = 1'b1;
      end else begin
         enq_data.write_enable = in_frame_ff;
         enq_data.from_source  = (mode_ff == MODE_IMAGE);
         enq_data.write_color  = (mode_ff == MODE_IMAGE) ? '0 : color_ff;
         enq_data.last         = last_ff;
         if (in_frame_ff) begin
            enq_data.write_address = waddr[crb_pkg::ADDR_W-1:0];
            if (mode_ff == MODE_IMAGE) begin
               enq_data.source_address = base_ff + {6'b0, sprod_ff} + {19'b0, sx_ff};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_MUL) begin
         wprod_ff    <= py[12:0] * pitch_ff;
         sprod_ff    <= sy_ff * sw_ff;
         pxl_ff      <= px[12:0];
         in_frame_ff <= in_frame;
         last_ff     <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_FETCH;
         mode_ff   <= MODE_IDLE;
         fw_ff     <= W'(640);
         fh_ff     <= W'(480);
         pitch_ff  <= 14'd640;
         scroll_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         left_ff   <= '0;
         top_ff    <= '0;
         w_ff      <= '0;
         h_ff      <= '0;
         sw_ff     <= '0;
         sh_ff     <= '0;
         color_ff  <= '0;
         base_ff   <= '0;
         qx_ff     <= '0;
         rx_ff     <= '0;
         qy_ff     <= '0;
         ry_ff     <= '0;
         sx_ff     <= '0;
         xr_ff     <= '0;
         sy_ff     <= '0;
         yr_ff     <= '0;
      end else begin
         st_ff    <= st_in;
         mode_ff  <= mode_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         left_ff  <= left_in;
         top_ff   <= top_in;
         w_ff     <= w_in;
         h_ff     <= h_in;
         sw_ff    <= sw_in;
         sh_ff    <= sh_in;
         color_ff <= color_in;
         base_ff  <= base_in;
         qx_ff    <= qx_in;
         rx_ff    <= rx_in;
         qy_ff    <= qy_in;
         ry_ff    <= ry_in;
         sx_ff    <= sx_in;
         xr_ff    <= xr_in;
         sy_ff    <= sy_in;
         yr_ff    <= yr_in;
         if (csr_we) begin
            unique case (csr_index)
               crb_pkg::CSR_FRAME_WIDTH:  fw_ff     <= csr_wdata[W-1:0];
               crb_pkg::CSR_FRAME_HEIGHT: fh_ff     <= csr_wdata[W-1:0];
               crb_pkg::CSR_ROW_PITCH:    pitch_ff  <= csr_wdata[13:0];
               crb_pkg::CSR_SCROLL:       scroll_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end
endmodule

### rtl/crb_checker.sv
// Port-level checks for the blitter top level, attached by bind.
// Depends on crb_pkg.
module crb_checker (
   input logic             clock,
   input logic             reset,
   input logic             full,
   input logic             empty,
   input logic             pop,
   input crb_pkg::rsp_type rsp_data
);
   a_reset_clear: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.write_enable) |->
      (rsp_data.write_address == '0 && rsp_data.source_address == '0))
      else $error("clipped word carries an address");

   a_source_color: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.from_source) |-> (rsp_data.write_color == '0))
      else $error("copy word carries a color");

   a_fill_source: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.from_source) |-> (rsp_data.source_address == '0))
      else $error("fill word carries a source address");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("stalled word changed");
endmodule

bind clipped_rect_fill_and_scaled_blit crb_checker u_crb_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

### tb/clipped_rect_fill_and_scaled_blit_tb.sv
// Testbench for the clipped rectangle fill and scaled blit engine.
// Predicts every result word from its own model of the engine and checks it in order.
// Depends on crb_pkg and the clipped_rect_fill_and_scaled_blit top level.
`timescale 1ns / 1ps

class blit_scoreboard;
   typedef enum logic [1:0] {ENG_IDLE, ENG_FILL, ENG_IMAGE} eng_mode_type;

   logic [12:0] frame_w, frame_h;
   logic [13:0] pitch;
   int          scroll;
   eng_mode_type mode;
   int unsigned col, row, width, height, src_w, src_h;
   int          left, top;
   logic [31:0] color, base;
   crb_pkg::rsp_type pending[$];
   int          mismatches, checked, steps_seen;

   function new();
      frame_w = 13'd640; frame_h = 13'd480; pitch = 14'd640; scroll = 0;
      mode = ENG_IDLE; col = 0; row = 0; width = 0; height = 0;
      src_w = 0; src_h = 0; left = 0; top = 0; color = '0; base = '0;
      mismatches = 0; checked = 0; steps_seen = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
         crb_pkg::CSR_FRAME_WIDTH:  frame_w = val[12:0];
         crb_pkg::CSR_FRAME_HEIGHT: frame_h = val[12:0];
         crb_pkg::CSR_ROW_PITCH:    pitch = val[13:0];
         default:                   scroll = $signed(val);
      endcase
   endfunction

   function int unsigned clamp_dim(logic [12:0] v);
      return (v > 4096) ? 4096 : v;
   endfunction

   function void note_word(crb_pkg::req_type r);
      crb_pkg::rsp_type o;
      longint px, py;
      logic in_frame, is_last, image;
      longint unsigned sy, sx;
      if (r.command == crb_pkg::CMD_FILL || r.command == crb_pkg::CMD_IMAGE) begin
         width = clamp_dim(r.rect_w); height = clamp_dim(r.rect_h);
         src_w = clamp_dim(r.source_width); src_h = clamp_dim(r.source_height);
         left = r.rect_x; top = int'(r.rect_y) - scroll;
         color = r.fill_color; base = r.source_base; col = 0; row = 0;
         if (width == 0 || height == 0 ||
             (r.command == crb_pkg::CMD_IMAGE && (src_w == 0 || src_h == 0)))
            mode = ENG_IDLE;
         else
            mode = (r.command == crb_pkg::CMD_FILL) ? ENG_FILL : ENG_IMAGE;
         return;
      end
      if (r.command != crb_pkg::CMD_STEP) return;
      steps_seen++;
      o = '0;
      if (mode == ENG_IDLE) begin
         o.last = 1'b1;
         pending.push_back(o);
         return;
      end
      px = longint'(left) + col;
      py = longint'(top) + row;
      in_frame = px >= 0 && py >= 0 && px < frame_w && py < frame_h;
      is_last = (col + 1 == width) && (row + 1 == height);
      image = (mode == ENG_IMAGE);
      if (in_frame) begin
         o.write_address = 25'(py * pitch + px);
         if (image) begin
            sy = longint'(row) * src_h / height;
            sx = longint'(col) * src_w / width;
            o.source_address = 32'(longint'(base) + sy * src_w + sx);
         end
      end
      o.write_enable = in_frame;
      o.from_source = image;
      o.write_color = image ? 32'd0 : color;
      o.last = is_last;
      pending.push_back(o);
      if (is_last) begin
         mode = ENG_IDLE; col = 0; row = 0;
      end else begin
         col++;
         if (col >= width) begin
            col = 0; row++;
         end
      end
   endfunction

   function void check_word(crb_pkg::rsp_type got);
      crb_pkg::rsp_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result word %h", got);
         return;
      end
      want = pending.pop_front();
      checked++;
      if (got.write_enable !== want.write_enable || got.write_address !== want.write_address ||
          got.from_source !== want.from_source || got.write_color !== want.write_color ||
          got.source_address !== want.source_address || got.last !== want.last) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %0d: expected we=%b addr=%h src=%b col=%h saddr=%h last=%b, got we=%b addr=%h src=%b col=%h saddr=%h last=%b",
               checked, want.write_enable, want.write_address, want.from_source,
               want.write_color, want.source_address, want.last,
               got.write_enable, got.write_address, got.from_source,
               got.write_color, got.source_address, got.last);
      end
   endfunction
endclass

module clipped_rect_fill_and_scaled_blit_tb;
   localparam int REQ_BITS = $bits(crb_pkg::req_type);

   logic clock = 0, reset = 1;
   logic push = 0, pop = 0, csr_we = 0;
   logic full, empty;
   crb_pkg::req_type req_data = '0;
   crb_pkg::rsp_type rsp_data;
   logic [1:0] csr_index = crb_pkg::CSR_FRAME_WIDTH;
   logic [15:0] csr_wdata = '0;

   blit_scoreboard board;
   int   cycle_count = 0;
   bit   quiet = 0, hold_off = 0;
   int   words_sent = 0;

   clipped_rect_fill_and_scaled_blit dut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1500000) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side: random pop bursts, plus one long hold
   initial begin
      int n;
      board = new();
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) board.check_word(rsp_data);
         if (hold_off) pop <= 0;
         else if (quiet) pop <= 1;
         else if ($urandom_range(0, 3) == 0) begin
            pop <= 0;
            n = $urandom_range(1, 16);
            repeat (n - 1) begin
               @(posedge clock);
               if (pop && !empty) board.check_word(rsp_data);
            end
         end else pop <= 1;
      end
   end

   task automatic send_word(crb_pkg::req_type r);
      int n;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         push <= 0;
         n = $urandom_range(1, 16);
         repeat (n) @(posedge clock);
      end
      req_data <= r;
      push <= 1;
      do @(posedge clock); while (full);
      board.note_word(r);
      words_sent++;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      board.write_reg(idx, val);
   endtask

   task automatic settle();
      push <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic crb_pkg::req_type start_word(logic [1:0] cmd, int w, int h,
                                                   int sw, int sh);
      crb_pkg::req_type r;
      r.command = cmd;
      r.rect_x = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40)) - 16'sd8;
      r.rect_y = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40)) - 16'sd8;
      r.rect_w = 13'(w); r.rect_h = 13'(h);
      r.fill_color = $urandom; r.source_width = 13'(sw); r.source_height = 13'(sh);
      r.source_base = $urandom;
      return r;
   endfunction

   function automatic crb_pkg::req_type step_word();
      crb_pkg::req_type r;
      r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
      r.command = crb_pkg::CMD_STEP;
      return r;
   endfunction

   task automatic run_cmd(crb_pkg::req_type s, int steps);
      send_word(s);
      repeat (steps) send_word(step_word());
   endtask

   initial begin
      crb_pkg::req_type r;
      int phase, n;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: idle step, each command, zero sizes, oversize, code 3, restart
      send_word(step_word());
      run_cmd(start_word(crb_pkg::CMD_FILL, 2, 2, 0, 0), 4);
      r = start_word(crb_pkg::CMD_IMAGE, 3, 2, 5, 7); r.source_base = 0;
      run_cmd(r, 6);
      run_cmd(start_word(crb_pkg::CMD_FILL, 0, 3, 1, 1), 1);
      run_cmd(start_word(crb_pkg::CMD_IMAGE, 2, 2, 0, 4), 1);
      r = start_word(crb_pkg::CMD_FILL, 8191, 8191, 8191, 8191);
      r.rect_x = 16'sh7fff; r.rect_y = -16'sh8000;
      run_cmd(r, 2);
      r = start_word(crb_pkg::CMD_IMAGE, 8191, 1, 8191, 8191);
      r.rect_x = 16'sh0; r.rect_y = 16'sh0; r.source_base = 32'hffffffff;
      run_cmd(r, 2);
      r = step_word(); r.command = crb_pkg::CMD_RSVD; send_word(r);
      run_cmd(start_word(crb_pkg::CMD_FILL, 1, 1, 0, 0), 2);
      settle();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(crb_pkg::CSR_FRAME_WIDTH, 16'd1);
               write_reg(crb_pkg::CSR_FRAME_HEIGHT, 16'd1);
               write_reg(crb_pkg::CSR_ROW_PITCH, 16'd1);
               write_reg(crb_pkg::CSR_SCROLL, 16'h8000);
            end
            1: begin
               write_reg(crb_pkg::CSR_FRAME_WIDTH, 16'd4096);
               write_reg(crb_pkg::CSR_FRAME_HEIGHT, 16'd4096);
               write_reg(crb_pkg::CSR_ROW_PITCH, 16'd8192);
               write_reg(crb_pkg::CSR_SCROLL, 16'h7fff);
            end
            5: begin
               write_reg(crb_pkg::CSR_FRAME_WIDTH, 16'd640);
               write_reg(crb_pkg::CSR_FRAME_HEIGHT, 16'd480);
               write_reg(crb_pkg::CSR_ROW_PITCH, 16'd640);
               write_reg(crb_pkg::CSR_SCROLL, 16'd0);
            end
            default: begin
               write_reg(crb_pkg::CSR_FRAME_WIDTH, 16'($urandom_range(4, 24)));
               write_reg(crb_pkg::CSR_FRAME_HEIGHT, 16'($urandom_range(4, 24)));
               write_reg(crb_pkg::CSR_ROW_PITCH, 16'($urandom_range(1, 16383)));
               write_reg(crb_pkg::CSR_SCROLL, 16'($urandom_range(0, 8)) - 16'd4);
            end
         endcase
         csr_we <= 0;
         if (phase == 2) fork
            begin
               hold_off = 1;
               repeat (300) @(posedge clock);
               hold_off = 0;
            end
         join_none
         if (phase == 5) quiet = 1;
         while (words_sent < 25 + (phase + 1) * 310) begin
            n = $urandom_range(0, 9);
            if (n == 0) send_word(step_word());
            else if (n == 1) begin
               r = step_word(); r.command = 2'($urandom_range(0, 3)); send_word(r);
            end else begin
               r = start_word($urandom_range(0, 1) ? crb_pkg::CMD_IMAGE : crb_pkg::CMD_FILL,
                              $urandom_range(1, 6), $urandom_range(1, 5),
                              $urandom_range(0, 9) == 0 ? 8191 : $urandom_range(1, 12),
                              $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 12));
               if ($urandom_range(0, 19) == 0) r.rect_w = 13'(4096 + $urandom_range(0, 4095));
               run_cmd(r, ($urandom_range(0, 3) == 0 || r.rect_w > 13'd4096)
                          ? $urandom_range(0, 40) : r.rect_w * r.rect_h);
            end
         end
         settle();
      end

      $display("checked %0d result words from %0d input words over six register settings",
               board.checked, words_sent);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
